>>> hw/rtl/cdnl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Chamfer distance package
// Shared widths, constants, payload types and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package cdnl_pkg;

  localparam int MaxRows = 256;
  localparam int MaxCols = 256;

  localparam int CfgW   = 9;
  localparam int CoordW = 9;
  localparam int ThrW   = 8;
  localparam int PixW   = 8;
  localparam int IdxW   = 8;
  localparam int DistW  = 14;

  localparam logic [DistW-1:0] Unreached = DistW'(10000);
  localparam logic [DistW-1:0] WEdge     = DistW'(3);
  localparam logic [DistW-1:0] WDiag     = DistW'(4);

  localparam logic [1:0] CfgHeight    = 2'd0;
  localparam logic [1:0] CfgWidth     = 2'd1;
  localparam logic [1:0] CfgThreshold = 2'd2;

  typedef enum logic [1:0] {
    ReqWrite = 2'd0,
    ReqRun   = 2'd1,
    ReqRead  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    NbCenter = 3'd0,
    Nb0      = 3'd1,
    Nb1      = 3'd2,
    Nb2      = 3'd3,
    Nb3      = 3'd4
  } nb_sel_e;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } label_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    label_t           lab;
  } word_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [IdxW-1:0] row_index;
    logic [IdxW-1:0] col_index;
    logic [PixW-1:0] pixel_value;
  } req_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             label_valid;
    logic [IdxW-1:0]  nearest_row;
    logic [IdxW-1:0]  nearest_col;
    logic             done_res;
  } res_t;

  typedef struct packed {
    logic    clr_step;
    logic    acc_write;
    logic    acc_nop;
    logic    acc_read;
    logic    read_resp;
    logic    run_init;
    logic    run_done;
    logic    rd_en;
    nb_sel_e rd_sel;
    logic    relax_en;
    nb_sel_e relax_sel;
    logic    wb;
    logic    next_pixel;
    logic    start_bwd;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic run_empty;
    logic pass_last;
    logic bwd;
    logic out_full;
  } stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/cdnl_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface cdnl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cdnl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Chamfer distance controller
// Sequences the memory clear, request handling and the two raster passes.
// ----------------------------------------------------------------------------
module cdnl_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     req_type_i,
  input  wire logic           out_ready_i,
  output logic                in_ready_o,
  input  wire cdnl_pkg::stat_t stat_i,
  output cdnl_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CENTER,
    ST_NB0,
    ST_NB1,
    ST_NB2,
    ST_NB3,
    ST_WB
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = !stat_i.out_full || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          unique case (req_type_i)
            cdnl_pkg::ReqWrite: begin
              cmd_o.acc_write = 1'b1;
            end
            cdnl_pkg::ReqRead: begin
              cmd_o.acc_read = 1'b1;
              state_d        = ST_READ;
            end
            cdnl_pkg::ReqRun: begin
              cmd_o.run_init = 1'b1;
              if (stat_i.run_empty) begin
                cmd_o.run_done = 1'b1;
              end else begin
                state_d = ST_CENTER;
              end
            end
            default: begin
              cmd_o.acc_nop = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.read_resp = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_CENTER: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = cdnl_pkg::NbCenter;
        state_d      = ST_NB0;
      end
      ST_NB0: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = cdnl_pkg::Nb0;
        cmd_o.relax_en  = 1'b1;
        cmd_o.relax_sel = cdnl_pkg::NbCenter;
        state_d         = ST_NB1;
      end
      ST_NB1: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = cdnl_pkg::Nb1;
        cmd_o.relax_en  = 1'b1;
        cmd_o.relax_sel = cdnl_pkg::Nb0;
        state_d         = ST_NB2;
      end
      ST_NB2: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = cdnl_pkg::Nb2;
        cmd_o.relax_en  = 1'b1;
        cmd_o.relax_sel = cdnl_pkg::Nb1;
        state_d         = ST_NB3;
      end
      ST_NB3: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = cdnl_pkg::Nb3;
        cmd_o.relax_en  = 1'b1;
        cmd_o.relax_sel = cdnl_pkg::Nb2;
        state_d         = ST_WB;
      end
      ST_WB: begin
        cmd_o.relax_en  = 1'b1;
        cmd_o.relax_sel = cdnl_pkg::Nb3;
        cmd_o.wb        = 1'b1;
        state_d         = ST_CENTER;
        if (stat_i.pass_last) begin
          if (stat_i.bwd) begin
            cmd_o.run_done = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.start_bwd = 1'b1;
          end
        end else begin
          cmd_o.next_pixel = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cdnl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Chamfer distance datapath
// Configuration registers, the distance/label memory, pass counters, the
// relaxation unit and the result register.
// ----------------------------------------------------------------------------
module cdnl_dp #(
  parameter int MAX_ROWS = cdnl_pkg::MaxRows,
  parameter int MAX_COLS = cdnl_pkg::MaxCols
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_idx_i,
  input  wire logic [cdnl_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire cdnl_pkg::req_t           req_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output cdnl_pkg::res_t                res_o,
  input  wire cdnl_pkg::cmd_t           cmd_i,
  output cdnl_pkg::stat_t               stat_o
);

  localparam int Depth  = MAX_ROWS * MAX_COLS;
  localparam int AddrW  = $clog2(Depth);
  localparam int CoordW = cdnl_pkg::CoordW;
  localparam int DistW  = cdnl_pkg::DistW;
  localparam int IdxW   = cdnl_pkg::IdxW;

  function automatic logic [AddrW-1:0] cell_addr(logic [CoordW-1:0] r, logic [CoordW-1:0] c);
    cell_addr = AddrW'(32'(r) * 32'(MAX_COLS) + 32'(c));
  endfunction

  function automatic logic [2*CoordW-1:0] nb_pos(cdnl_pkg::nb_sel_e sel,
                                                  logic [CoordW-1:0] r,
                                                  logic [CoordW-1:0] c,
                                                  logic bwd);
    logic [CoordW-1:0] rs;
    logic [CoordW-1:0] cs;
    logic [CoordW-1:0] rn;
    logic [CoordW-1:0] cn;
    rs = bwd ? r + CoordW'(1) : r - CoordW'(1);
    cs = bwd ? c + CoordW'(1) : c - CoordW'(1);
    rn = r;
    cn = c;
    unique case (sel)
      cdnl_pkg::Nb0: begin
        rn = rs;
        cn = c - CoordW'(1);
      end
      cdnl_pkg::Nb1: begin
        rn = rs;
      end
      cdnl_pkg::Nb2: begin
        rn = rs;
        cn = c + CoordW'(1);
      end
      cdnl_pkg::Nb3: begin
        cn = cs;
      end
      default: begin
        rn = r;
      end
    endcase
    nb_pos = {rn, cn};
  endfunction

  logic [cdnl_pkg::CfgW-1:0] cfg_h_q, cfg_w_q;
  logic [cdnl_pkg::ThrW-1:0] thr_q;
  logic [CoordW-1:0]         eff_h, eff_w, h2, w2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q <= cdnl_pkg::CfgW'(256);
      cfg_w_q <= cdnl_pkg::CfgW'(256);
      thr_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cdnl_pkg::CfgHeight:    cfg_h_q <= cfg_wdata_i;
        cdnl_pkg::CfgWidth:     cfg_w_q <= cfg_wdata_i;
        cdnl_pkg::CfgThreshold: thr_q   <= cfg_wdata_i[cdnl_pkg::ThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eff_h = (32'(cfg_h_q) > 32'(MAX_ROWS)) ? CoordW'(MAX_ROWS) : cfg_h_q;
  assign eff_w = (32'(cfg_w_q) > 32'(MAX_COLS)) ? CoordW'(MAX_COLS) : cfg_w_q;
  assign h2    = eff_h - CoordW'(2);
  assign w2    = eff_w - CoordW'(2);

  logic [CoordW-1:0] in_row, in_col;
  logic              in_image;

  assign in_row   = CoordW'(req_i.row_index);
  assign in_col   = CoordW'(req_i.col_index);
  assign in_image = (in_row < eff_h) && (in_col < eff_w);

  logic [CoordW-1:0] r_q, r_d, c_q, c_d;
  logic              bwd_q, bwd_d;
  logic [AddrW-1:0]  clr_q;
  logic              rd_ok_q;

  always_comb begin
    r_d   = r_q;
    c_d   = c_q;
    bwd_d = bwd_q;
    if (cmd_i.run_init) begin
      r_d   = CoordW'(1);
      c_d   = CoordW'(1);
      bwd_d = 1'b0;
    end else if (cmd_i.start_bwd) begin
      r_d   = h2;
      c_d   = w2;
      bwd_d = 1'b1;
    end else if (cmd_i.next_pixel) begin
      if (bwd_q) begin
        if (c_q == CoordW'(1)) begin
          c_d = w2;
          r_d = r_q - CoordW'(1);
        end else begin
          c_d = c_q - CoordW'(1);
        end
      end else begin
        if (c_q == w2) begin
          c_d = CoordW'(1);
          r_d = r_q + CoordW'(1);
        end else begin
          c_d = c_q + CoordW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q     <= '0;
      c_q     <= '0;
      bwd_q   <= 1'b0;
      clr_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      r_q   <= r_d;
      c_q   <= c_d;
      bwd_q <= bwd_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cmd_i.acc_read) begin
        rd_ok_q <= in_image;
      end
    end
  end

  cdnl_pkg::word_t   mem_q [Depth];
  cdnl_pkg::word_t   mem_rdata_q;
  cdnl_pkg::word_t   mem_wdata;
  logic [AddrW-1:0]  mem_addr;
  logic              mem_we, mem_re;

  logic [2*CoordW-1:0] rd_pos, rl_pos;
  logic [CoordW-1:0]   rl_row, rl_col;
  logic [DistW-1:0]    dmin_q, dmin_new;
  cdnl_pkg::label_t    lab_q, lab_new, self_lab, src_lab;
  logic [DistW:0]      cand;
  logic [DistW-1:0]    weight;

  assign rd_pos = nb_pos(cmd_i.rd_sel, r_q, c_q, bwd_q);
  assign rl_pos = nb_pos(cmd_i.relax_sel, r_q, c_q, bwd_q);
  assign rl_row = rl_pos[2*CoordW-1:CoordW];
  assign rl_col = rl_pos[CoordW-1:0];

  always_comb begin
    self_lab.valid = 1'b1;
    self_lab.row   = rl_row[IdxW-1:0];
    self_lab.col   = rl_col[IdxW-1:0];
    src_lab        = (mem_rdata_q.distance == '0) ? self_lab : mem_rdata_q.lab;
    weight         = ((cmd_i.relax_sel == cdnl_pkg::Nb0) || (cmd_i.relax_sel == cdnl_pkg::Nb2))
                     ? cdnl_pkg::WDiag : cdnl_pkg::WEdge;
    cand           = {1'b0, mem_rdata_q.distance} + {1'b0, weight};
    dmin_new       = dmin_q;
    lab_new        = lab_q;
    if (cmd_i.relax_sel == cdnl_pkg::NbCenter) begin
      dmin_new = mem_rdata_q.distance;
      lab_new  = src_lab;
    end else if (cand < {1'b0, dmin_q}) begin
      dmin_new = cand[DistW-1:0];
      lab_new  = src_lab;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.relax_en) begin
      dmin_q <= dmin_new;
      lab_q  <= lab_new;
    end
  end

  always_comb begin
    mem_addr  = cell_addr(r_q, c_q);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;
    priority if (cmd_i.clr_step) begin
      mem_addr = clr_q;
      mem_we   = 1'b1;
    end else if (cmd_i.acc_write) begin
      mem_addr           = cell_addr(in_row, in_col);
      mem_we             = in_image;
      mem_wdata.distance = (req_i.pixel_value <= thr_q) ? '0 : cdnl_pkg::Unreached;
    end else if (cmd_i.acc_read) begin
      mem_addr = cell_addr(in_row, in_col);
      mem_re   = in_image;
    end else if (cmd_i.rd_en) begin
      mem_addr = cell_addr(rd_pos[2*CoordW-1:CoordW], rd_pos[CoordW-1:0]);
      mem_re   = 1'b1;
    end else if (cmd_i.wb) begin
      mem_we             = 1'b1;
      mem_wdata.distance = dmin_new;
      mem_wdata.lab      = lab_new;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  logic           out_valid_q, out_valid_d, out_load;
  cdnl_pkg::res_t res_q, res_d;

  assign out_load = cmd_i.acc_write || cmd_i.acc_nop || cmd_i.read_resp || cmd_i.run_done;

  always_comb begin
    res_d       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.acc_write) begin
      res_d.done_res = in_image;
    end else if (cmd_i.run_done) begin
      res_d.done_res = 1'b1;
    end else if (cmd_i.read_resp && rd_ok_q) begin
      res_d.distance    = mem_rdata_q.distance;
      res_d.label_valid = mem_rdata_q.lab.valid;
      res_d.nearest_row = mem_rdata_q.lab.valid ? mem_rdata_q.lab.row : '0;
      res_d.nearest_col = mem_rdata_q.lab.valid ? mem_rdata_q.lab.col : '0;
      res_d.done_res    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign stat_o.clear_last = (clr_q == AddrW'(Depth - 1));
  assign stat_o.run_empty  = (eff_h < CoordW'(3)) || (eff_w < CoordW'(3));
  assign stat_o.pass_last  = bwd_q ? ((r_q == CoordW'(1)) && (c_q == CoordW'(1)))
                                   : ((r_q == h2) && (c_q == w2));
  assign stat_o.bwd        = bwd_q;
  assign stat_o.out_full   = out_valid_q;

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory port asked to read and write in one cycle");

  a_relax_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.relax_en && (cmd_i.relax_sel != cdnl_pkg::NbCenter)) |=> (dmin_q <= $past(dmin_q)))
    else $error("relaxation increased a distance");

  a_wb_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |-> ((mem_wdata.distance != '0) || mem_wdata.lab.valid))
    else $error("stroke pixel written back without a label");

  a_wb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |-> (mem_wdata.distance <= cdnl_pkg::Unreached))
    else $error("written back distance above unreached value");

endmodule
`default_nettype wire

>>> hw/rtl/chamfer_distance_nearest_label.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Chamfer distance transform with nearest stroke labels
// 3-4 chamfer distance over a stored image, tracking the nearest stroke pixel.
// ----------------------------------------------------------------------------
// After reset the block clears its MAX_ROWS*MAX_COLS entry memory, one entry
// per cycle, and accepts no request beat during those cycles. A pixel read
// passes through an extra read state, since the single memory port returns
// registered data. A run visits every interior pixel twice, forward then
// backward, and each visit takes five reads and a write-back on the one
// memory port. Every request beat returns exactly one result beat.
module chamfer_distance_nearest_label #(
  parameter int MAX_ROWS = cdnl_pkg::MaxRows,
  parameter int MAX_COLS = cdnl_pkg::MaxCols
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [cdnl_pkg::CfgW-1:0] cfg_wdata_i,
  cdnl_stream_if.sink                    req_i,
  cdnl_stream_if.source                  res_o
);

  cdnl_pkg::cmd_t  cmd;
  cdnl_pkg::stat_t stat;
  cdnl_pkg::req_t  req_data;
  cdnl_pkg::res_t  res_data;
  logic            in_ready;
  logic            out_valid;

  assign req_data    = req_i.data;
  assign req_i.ready = in_ready;
  assign res_o.valid = out_valid;
  assign res_o.data  = res_data;

  cdnl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .req_type_i  (req_data.req_type),
    .out_ready_i (res_o.ready),
    .in_ready_o  (in_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdnl_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_data),
    .out_ready_i (res_o.ready),
    .out_valid_o (out_valid),
    .res_o       (res_data),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chamfer distance transform testbench
// Drives pixel writes, transform runs and reads through the request channel.
// A local image model predicts each response beat, which is compared field
// by field in order. Both channel sides idle and stall at random, and the
// response side holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module testbench;
  import cdnl_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int Cells = MaxRows * MaxCols;
  localparam int WatchdogLimit = 400000;
  localparam int ItemTarget = 1850;
  localparam int StallCycles = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;

  cdnl_stream_if #(.payload_t(req_t)) req_if ();
  cdnl_stream_if #(.payload_t(res_t)) res_if ();

  chamfer_distance_nearest_label dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  logic [DistW-1:0] dist_img [Cells];
  label_t label_img [Cells];
  bit written_img [Cells];
  int cfg_height;
  int cfg_width;
  int cfg_thr;

  res_t awaited_responses [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit no_idle = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_rows();
    return (cfg_height > MaxRows) ? MaxRows : cfg_height;
  endfunction

  function automatic int eff_cols();
    return (cfg_width > MaxCols) ? MaxCols : cfg_width;
  endfunction

  function automatic int cell_index(input int r, input int c);
    return r * MaxCols + c;
  endfunction

  function automatic void relax_from(inout int dmin, inout label_t lab, input int nr,
                                     input int nc, input int weight);
    int n;
    int cand;
    n = cell_index(nr, nc);
    cand = int'(dist_img[n]) + weight;
    if (cand < dmin) begin
      dmin = cand;
      if (dist_img[n] == DistW'(0)) begin
        lab.valid = 1'b1;
        lab.row = IdxW'(nr);
        lab.col = IdxW'(nc);
      end else begin
        lab = label_img[n];
      end
    end
  endfunction

  function automatic void visit_pixel(input int r, input int c, input int dr);
    int idx;
    int dmin;
    label_t lab;
    idx = cell_index(r, c);
    dmin = int'(dist_img[idx]);
    lab = label_img[idx];
    if (dmin == 0) begin
      lab.valid = 1'b1;
      lab.row = IdxW'(r);
      lab.col = IdxW'(c);
    end else begin
      relax_from(dmin, lab, r + dr, c - 1, int'(WDiag));
      relax_from(dmin, lab, r + dr, c, int'(WEdge));
      relax_from(dmin, lab, r + dr, c + 1, int'(WDiag));
      relax_from(dmin, lab, r, c + dr, int'(WEdge));
    end
    dist_img[idx] = DistW'(dmin);
    label_img[idx] = lab;
  endfunction

  function automatic res_t model_response(input req_t item);
    res_t resp;
    int idx;
    int h;
    int w;
    bit in_image;
    resp = '0;
    h = eff_rows();
    w = eff_cols();
    in_image = (int'(item.row_index) < h) && (int'(item.col_index) < w);
    idx = cell_index(int'(item.row_index), int'(item.col_index));
    case (item.req_type)
      ReqWrite: begin
        if (in_image) begin
          dist_img[idx] = (int'(item.pixel_value) <= cfg_thr) ? DistW'(0) : Unreached;
          label_img[idx] = '0;
          written_img[idx] = 1'b1;
          resp.done_res = 1'b1;
        end
      end
      ReqRun: begin
        for (int r = 1; r <= h - 2; r++) begin
          for (int c = 1; c <= w - 2; c++) visit_pixel(r, c, -1);
        end
        for (int r = h - 2; r >= 1; r--) begin
          for (int c = w - 2; c >= 1; c--) visit_pixel(r, c, 1);
        end
        resp.done_res = 1'b1;
      end
      ReqRead: begin
        if (in_image) begin
          resp.distance = dist_img[idx];
          if (label_img[idx].valid) begin
            resp.label_valid = 1'b1;
            resp.nearest_row = label_img[idx].row;
            resp.nearest_col = label_img[idx].col;
          end
          resp.done_res = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  task automatic send_req(input logic [1:0] kind, input int row, input int col, input int pix);
    req_t item;
    int gap;
    item.req_type = kind;
    item.row_index = IdxW'(row);
    item.col_index = IdxW'(col);
    item.pixel_value = PixW'(pix);
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    awaited_responses.push_back(model_response(item));
    items_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgHeight: cfg_height = value & 'h1FF;
      CfgWidth: cfg_width = value & 'h1FF;
      default: cfg_thr = value & 'hFF;
    endcase
  endtask

  task automatic set_config(input int h, input int w, input int thr);
    wait_drained();
    write_reg(CfgHeight, h);
    write_reg(CfgWidth, w);
    write_reg(CfgThreshold, thr);
  endtask

  function automatic int pick_pixel();
    int v;
    if ($urandom_range(0, 5) == 0) v = $urandom_range(0, cfg_thr);
    else if (cfg_thr < 255) v = $urandom_range(cfg_thr + 1, 255);
    else v = $urandom_range(0, 255);
    return v;
  endfunction

  function automatic bit image_ready();
    int h;
    int w;
    h = eff_rows();
    w = eff_cols();
    if (h < 3 || w < 3) return 1'b1;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (!written_img[cell_index(r, c)]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic fill_image();
    int h;
    int w;
    bit fresh;
    h = eff_rows();
    w = eff_cols();
    fresh = (h * w) <= 200;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (fresh || !written_img[cell_index(r, c)]) send_req(ReqWrite, r, c, pick_pixel());
      end
    end
  endtask

  task automatic outside_op();
    int h;
    int w;
    logic [1:0] kind;
    h = eff_rows();
    w = eff_cols();
    kind = $urandom_range(0, 1) ? ReqRead : ReqWrite;
    if (h < MaxRows && (w == MaxCols || $urandom_range(0, 1))) begin
      send_req(kind, $urandom_range(h, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (w < MaxCols) begin
      send_req(kind, $urandom_range(0, 255), $urandom_range(w, 255), $urandom_range(0, 255));
    end else begin
      send_req(ReqUnused, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255));
    end
  endtask

  task automatic read_inside();
    int r;
    int c;
    if (eff_rows() == 0 || eff_cols() == 0) begin
      outside_op();
      return;
    end
    r = $urandom_range(0, eff_rows() - 1);
    c = $urandom_range(0, eff_cols() - 1);
    if (!written_img[cell_index(r, c)]) send_req(ReqWrite, r, c, pick_pixel());
    send_req(ReqRead, r, c, $urandom_range(0, 255));
  endtask

  task automatic random_op();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel <= 10) begin
      read_inside();
    end else if (sel <= 12) begin
      if (image_ready()) begin
        send_req(ReqRun, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
      end else begin
        read_inside();
      end
    end else if (sel <= 14) begin
      if (eff_rows() > 0 && eff_cols() > 0) begin
        send_req(ReqWrite, $urandom_range(0, eff_rows() - 1), $urandom_range(0, eff_cols() - 1),
                 pick_pixel());
      end else begin
        outside_op();
      end
    end else if (sel <= 17) begin
      outside_op();
    end else begin
      send_req(ReqUnused, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255));
    end
  endtask

  task automatic test_directed();
    send_req(ReqWrite, 0, 0, 0);
    send_req(ReqWrite, 255, 255, 255);
    send_req(ReqWrite, 0, 255, 1);
    send_req(ReqRead, 0, 0, 0);
    send_req(ReqRead, 255, 255, 0);
    send_req(ReqRead, 0, 255, 255);
    send_req(ReqUnused, 255, 255, 255);
    set_config(3, 3, 128);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) send_req(ReqWrite, r, c, (r == 0 && c == 0) ? 128 : 129);
    end
    send_req(ReqRun, 0, 0, 0);
    send_req(ReqRead, 1, 1, 0);
    send_req(ReqRead, 2, 2, 0);
    send_req(ReqWrite, 3, 0, 0);
    send_req(ReqRead, 0, 3, 0);
    send_req(ReqWrite, 1, 1, 7);
    send_req(ReqRead, 1, 1, 0);
    send_req(ReqRun, 255, 255, 255);
    send_req(ReqRead, 1, 1, 0);
    set_config(2, 256, 128);
    send_req(ReqRun, 0, 0, 0);
    send_req(ReqRead, 0, 0, 0);
    set_config(511, 3, 255);
    send_req(ReqWrite, 255, 2, 255);
    send_req(ReqRead, 255, 2, 0);
  endtask

  // The response side stops taking beats for a long stretch while requests keep coming.
  task automatic test_output_stall();
    set_config(3, 3, $urandom_range(0, 255));
    no_idle = 1'b1;
    hold_cycles = StallCycles;
    repeat (40) random_op();
    no_idle = 1'b0;
  endtask

  task automatic test_tall_image();
    set_config(256, 3, $urandom_range(0, 255));
    fill_image();
    send_req(ReqRun, 0, 0, 0);
    repeat (20) read_inside();
    send_req(ReqRun, 0, 0, 0);
    repeat (10) read_inside();
  endtask

  task automatic test_random_phases();
    int kind;
    int h;
    int w;
    int thr;
    while (items_sent < ItemTarget) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          h = $urandom_range(0, 2);
          w = $urandom_range(0, 511);
        end
        1: begin
          h = $urandom_range(0, 511);
          w = $urandom_range(0, 2);
        end
        2: begin
          h = $urandom_range(257, 511);
          w = 3;
        end
        default: begin
          h = $urandom_range(3, 10);
          w = $urandom_range(3, 10);
        end
      endcase
      if ($urandom_range(0, 3) == 0) thr = $urandom_range(0, 1) ? 255 : 0;
      else thr = $urandom_range(0, 255);
      set_config(h, w, thr);
      no_idle = ($urandom_range(0, 3) == 0);
      if (eff_rows() >= 3 && eff_cols() >= 3) fill_image();
      if (image_ready()) send_req(ReqRun, $urandom_range(0, 255), 0, 0);
      repeat ($urandom_range(8, 20)) random_op();
    end
    no_idle = 1'b0;
  endtask

  initial begin : response_check
    int stall;
    res_t got;
    res_t want;
    res_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got = res_if.data;
      if (awaited_responses.size() == 0) begin
        $display("%0t: response beat with none awaited: expected nothing, actual %h",
                 $time, got);
        mismatch_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (got.distance !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                   got.distance);
          mismatch_count++;
        end
        if (got.label_valid !== want.label_valid) begin
          $display("%0t: label_valid expected %0b actual %0b", $time, want.label_valid,
                   got.label_valid);
          mismatch_count++;
        end
        if (got.nearest_row !== want.nearest_row) begin
          $display("%0t: nearest_row expected %0d actual %0d", $time, want.nearest_row,
                   got.nearest_row);
          mismatch_count++;
        end
        if (got.nearest_col !== want.nearest_col) begin
          $display("%0t: nearest_col expected %0d actual %0d", $time, want.nearest_col,
                   got.nearest_col);
          mismatch_count++;
        end
        if (got.done_res !== want.done_res) begin
          $display("%0t: done_res expected %0b actual %0b", $time, want.done_res,
                   got.done_res);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WatchdogLimit);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : main_sequence
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgHeight;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_height = MaxRows;
    cfg_width = MaxCols;
    cfg_thr = 0;
    foreach (label_img[i]) begin
      label_img[i] = '0;
      dist_img[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_output_stall();
    test_tall_image();
    test_random_phases();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (awaited_responses.size() != 0) begin
      $display("%0t: %0d responses expected, none arrived", $time, awaited_responses.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
